>>> rtl/core/decctr_pkg.sv
// ----------------------------------------------------------------------------
// decctr_pkg
// shared widths, register indexes and sequencer states of the decaying
// event counter
// ----------------------------------------------------------------------------
package decctr_pkg;

  localparam int unsigned TIME_W    = 31;
  localparam int unsigned AMT_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_THRESHOLD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_THRESHOLD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_PERIOD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITOR_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TIME       = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DECAY,
    ST_ADD,
    ST_DONE
  } decctr_state_e;

endpackage

>>> rtl/core/decaying_event_counter.sv
// ----------------------------------------------------------------------------
// decaying_event_counter
// event counter whose count decays by elapsed time over a decay period
// ----------------------------------------------------------------------------
// Input beats (event_time_i, add_amount_i) are taken when in_valid_i is high
// and in_stall_o is low. in_stall_o stays high while one beat is in work.
// With decay active the elapsed time is divided by the decay period in a
// serial divider, one quotient bit per cycle. A beat runs through accept,
// divide, decay, add and commit steps; without decay the divider is skipped.
// The result beat (in_window_o, stored_count_o) sits in an output register
// with out_valid_o; while out_stall_i holds it, a finished beat waits in the
// commit step and the count is not updated until the register frees.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once
// and must be made only while idle; the block does not enforce this. Writing
// start_time also loads the last update time. Reset clears the configuration
// registers, the count and the last update time, and leaves no result pending.
// ----------------------------------------------------------------------------
module decaying_event_counter
  import decctr_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 31
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [TIME_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [TIME_W-1:0]    event_time_i,
  input  logic [AMT_W-1:0]     add_amount_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 in_window_o,
  output logic [TIME_W-1:0]    stored_count_o
);

  localparam int unsigned WIDE_W = ((COUNT_WIDTH > TIME_W) ? COUNT_WIDTH : TIME_W) + 1;
  localparam logic [WIDE_W-1:0] CMAX_W = WIDE_W'({COUNT_WIDTH{1'b1}});

  // configuration registers
  logic [TIME_W-1:0] min_q, max_q, period_q;
  logic              cap_en_q, lim_en_q;

  // state
  logic [COUNT_WIDTH-1:0] count_q;
  logic [TIME_W-1:0]      last_q;

  // beat in work
  decctr_state_e          state_q, state_d;
  logic [TIME_W-1:0]      now_q, mn_q, mx_q;
  logic [AMT_W-1:0]       amt_q;
  logic                   cap_q, lim_q, neg_q, go_q, qnz_q;
  logic [COUNT_WIDTH-1:0] work_q;
  logic [WIDE_W-1:0]      mxp1_q;

  // result register
  logic                   out_valid_q;
  logic                   window_q;
  logic [TIME_W-1:0]      out_count_q;

  // sequencer outputs
  logic accept, div_start, commit;

  // accept-time logic
  logic              swap, cap_now;
  logic [TIME_W-1:0] mn_now, mx_now, mag;
  logic              neg_now, go_now;

  // divider
  logic              div_done;
  logic [TIME_W-1:0] quot;

  // datapath steps
  logic [WIDE_W-1:0]      q_eff, cnt_w, mx_w, mn_w, sum_up, sum_add, mxp1_raw;
  logic [COUNT_WIDTH-1:0] decayed, added, final_cnt;
  logic                   window_now;

  assign swap    = (min_q != '0) && (max_q != '0) && (max_q < min_q);
  assign mn_now  = swap ? max_q : min_q;
  assign mx_now  = swap ? min_q : max_q;
  assign cap_now = cap_en_q && (mn_now > TIME_W'(1));
  assign neg_now = event_time_i < last_q;
  assign mag     = neg_now ? (last_q - event_time_i) : (event_time_i - last_q);
  assign go_now  = (period_q != '0) && (last_q != '0) && (count_q != '0);

  decctr_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag),
    .divisor_i  (period_q),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = go_now ? ST_DIV : ST_DECAY;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_DECAY;
        end
      end
      ST_DECAY: state_d = ST_ADD;
      ST_ADD:   state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    accept     = (state_q == ST_IDLE) && in_valid_i;
    div_start  = accept && go_now;
    commit     = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // decay, add and window steps
  assign q_eff    = go_q ? WIDE_W'(quot) : '0;
  assign cnt_w    = WIDE_W'(work_q);
  assign mx_w     = WIDE_W'(mx_q);
  assign mn_w     = WIDE_W'(mn_q);
  assign sum_up   = cnt_w + q_eff;
  assign sum_add  = cnt_w + WIDE_W'(amt_q);
  assign mxp1_raw = mx_w + WIDE_W'(1);

  always_comb begin
    if (neg_q) begin
      decayed = (sum_up > CMAX_W) ? COUNT_WIDTH'(CMAX_W) : COUNT_WIDTH'(sum_up);
    end else begin
      decayed = (q_eff >= cnt_w) ? '0 : COUNT_WIDTH'(cnt_w - q_eff);
    end
  end

  always_comb begin
    if (sum_add > CMAX_W) begin
      added = COUNT_WIDTH'(CMAX_W);
    end else begin
      added = COUNT_WIDTH'(sum_add);
    end
    if (lim_q && (WIDE_W'(added) > mx_w)) begin
      added = COUNT_WIDTH'(mxp1_q);
    end
  end

  assign window_now = (cnt_w >= mn_w) && ((mx_q == '0) || (cnt_w <= mx_w));
  assign final_cnt  = (cap_q && (cnt_w >= mn_w)) ? '0 : work_q;

  // beat registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q  <= event_time_i;
      amt_q  <= add_amount_i;
      mn_q   <= mn_now;
      mx_q   <= mx_now;
      cap_q  <= cap_now;
      lim_q  <= lim_en_q && (mx_now != '0) && !cap_now;
      neg_q  <= neg_now;
      go_q   <= go_now;
      work_q <= count_q;
    end else if (state_q == ST_DECAY) begin
      work_q <= decayed;
      qnz_q  <= (q_eff != '0);
      mxp1_q <= (mxp1_raw > CMAX_W) ? CMAX_W : mxp1_raw;
    end else if (state_q == ST_ADD) begin
      work_q <= added;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (commit) begin
      window_q <= window_now;
      if (work_q != count_q) begin
        out_count_q <= TIME_W'(final_cnt);
      end else begin
        out_count_q <= TIME_W'(count_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // configuration and counter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= '0;
      max_q    <= '0;
      period_q <= '0;
      cap_en_q <= 1'b0;
      lim_en_q <= 1'b0;
      count_q  <= '0;
      last_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_THRESHOLD:    min_q    <= cfg_data_i;
          CFG_MAX_THRESHOLD:    max_q    <= cfg_data_i;
          CFG_DECAY_PERIOD:     period_q <= cfg_data_i;
          CFG_CAPACITOR_ENABLE: cap_en_q <= cfg_data_i[0];
          CFG_LIMIT_ENABLE:     lim_en_q <= cfg_data_i[0];
          CFG_START_TIME:       last_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (commit) begin
        if (work_q != count_q) begin
          count_q <= final_cnt;
        end
        if ((work_q != count_q) || qnz_q) begin
          last_q <= now_q;
        end
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign in_window_o    = window_q;
  assign stored_count_o = out_count_q;

endmodule

>>> rtl/core/decctr_divider.sv
// ----------------------------------------------------------------------------
// decctr_divider
// restoring divider, one quotient bit per cycle; the quotient stays valid
// from the cycle after done_o until the next start
// ----------------------------------------------------------------------------
module decctr_divider
  import decctr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [TIME_W-1:0] dividend_i,
  input  logic [TIME_W-1:0] divisor_i,
  output logic              done_o,
  output logic [TIME_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = $clog2(TIME_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(TIME_W - 1);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [TIME_W-1:0] rem_q, quo_q, dvs_q;
  logic [TIME_W:0]   trial, diff;
  logic              ge;

  assign trial = {rem_q, quo_q[TIME_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (busy_q) begin
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      quo_q <= {quo_q[TIME_W-2:0], ge};
    end
  end

  assign done_o     = busy_q && (step_q == STEP_LAST);
  assign quotient_o = quo_q;

endmodule
